// ----- design/sts_pkg.sv -----
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants for the source trust score table
// Operation and status codes, reset values of the control registers, and
// the beat and control structs that pass between the table modules.
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF = 64;
   localparam int unsigned SCORE_W           = 7;
   localparam int unsigned KEY_W             = 32;
   localparam int unsigned PENALTY_W         = 8;
   localparam int unsigned CSR_ADDR_W        = 4;
   localparam int unsigned CSR_DATA_W        = 32;

   localparam logic [SCORE_W-1:0] MIN_SCORE_RST   = 7'd50;
   localparam logic [SCORE_W-1:0] ANON_SCORE_RST  = 7'd80;
   localparam logic [SCORE_W-1:0] MFA_SCORE_RST   = 7'd100;
   localparam logic [SCORE_W-1:0] PLAIN_SCORE_RST = 7'd90;

   typedef enum logic [1:0] {
      OP_EVALUATE     = 2'd0,
      OP_PENALIZE     = 2'd1,
      OP_AUTHENTICATE = 2'd2,
      OP_RESERVED     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_FOUND   = 2'd0,
      ST_CREATED = 2'd1,
      ST_FULL    = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_MIN_SCORE   = 2'd0,
      REG_ANON_SCORE  = 2'd1,
      REG_MFA_SCORE   = 2'd2,
      REG_PLAIN_SCORE = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [1:0]           op;
      logic [KEY_W-1:0]     src_address;
      logic [PENALTY_W-1:0] penalty_points;
      logic                 mfa_passed;
   } req_type;

   typedef struct packed {
      logic               allow;
      logic [SCORE_W-1:0] score;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [SCORE_W-1:0] min_score;
      logic [SCORE_W-1:0] anonymous_score;
      logic [SCORE_W-1:0] mfa_score;
      logic [SCORE_W-1:0] plain_score;
   } cfg_type;

   // lookup outcome for the key currently in the input register
   typedef struct packed {
      logic               hit;
      logic               full;
      logic [SCORE_W-1:0] score;
   } lookup_type;

   // update request: write score to the hit entry, or claim the lowest free one
   typedef struct packed {
      logic               wr_en;
      logic [SCORE_W-1:0] wr_score;
   } update_type;

endpackage

// ----- design/sts_csr.sv -----
// ----------------------------------------------------------------------------
// sts_csr: control registers
// APB-style register file holding the four score settings; always ready.
// ----------------------------------------------------------------------------
module sts_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sts_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [sts_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [sts_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output sts_pkg::cfg_type                  cfg
);
   import sts_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          wr_beat;
   logic [SCORE_W-1:0] rd_val;

   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[3:2]);
   assign wr_beat = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_beat) begin
         unique case (reg_sel)
            REG_MIN_SCORE:   cfg_in.min_score       = pwdata[SCORE_W-1:0];
            REG_ANON_SCORE:  cfg_in.anonymous_score = pwdata[SCORE_W-1:0];
            REG_MFA_SCORE:   cfg_in.mfa_score       = pwdata[SCORE_W-1:0];
            REG_PLAIN_SCORE: cfg_in.plain_score     = pwdata[SCORE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_MIN_SCORE:   rd_val = cfg_ff.min_score;
         REG_ANON_SCORE:  rd_val = cfg_ff.anonymous_score;
         REG_MFA_SCORE:   rd_val = cfg_ff.mfa_score;
         REG_PLAIN_SCORE: rd_val = cfg_ff.plain_score;
         default:         rd_val = '0;
      endcase
   end

   assign prdata = {{(CSR_DATA_W-SCORE_W){1'b0}}, rd_val};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_score       <= MIN_SCORE_RST;
         cfg_ff.anonymous_score <= ANON_SCORE_RST;
         cfg_ff.mfa_score       <= MFA_SCORE_RST;
         cfg_ff.plain_score     <= PLAIN_SCORE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

`ifndef SYNTH
   a_write_lands: assert property (@(posedge clock) disable iff (reset)
      wr_beat && reg_sel == REG_MIN_SCORE |=> cfg_ff.min_score == $past(pwdata[SCORE_W-1:0]))
      else $error("min_score write lost");
   a_no_write_holds: assert property (@(posedge clock) disable iff (reset)
      !wr_beat |=> $stable(cfg_ff))
      else $error("control register changed without a write beat");
   a_read_matches: assert property (@(posedge clock) disable iff (reset)
      reg_sel == REG_PLAIN_SCORE |-> prdata[SCORE_W-1:0] == cfg_ff.plain_score)
      else $error("plain_score readback mismatch");
`endif

endmodule

// ----- design/sts_table.sv -----
// ----------------------------------------------------------------------------
// sts_table: trust entry storage
// Per-entry key, score and valid flops. Parallel key compare against all
// valid entries, lowest-free-entry pick, and single-entry update per cycle.
// ----------------------------------------------------------------------------
module sts_table #(
   parameter int unsigned TABLE_ENTRIES = sts_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sts_pkg::KEY_W-1:0]     key,
   input  sts_pkg::update_type           upd,
   output sts_pkg::lookup_type           lkup
);
   import sts_pkg::*;

   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [KEY_W-1:0]         key_ff   [TABLE_ENTRIES];
   logic [SCORE_W-1:0]       score_ff [TABLE_ENTRIES];

   logic [TABLE_ENTRIES-1:0] match;
   logic [TABLE_ENTRIES-1:0] free;
   logic [TABLE_ENTRIES-1:0] first_free;
   logic [TABLE_ENTRIES-1:0] wr_sel;
   logic [SCORE_W-1:0]       hit_score;

   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == key);
      end
   end

   // isolate lowest clear valid bit
   assign free       = ~valid_ff;
   assign first_free = free & (~free + {{(TABLE_ENTRIES-1){1'b0}}, 1'b1});

   // keys are unique, so at most one match; OR the selected scores
   always_comb begin
      hit_score = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         hit_score = hit_score | (score_ff[i] & {SCORE_W{match[i]}});
      end
   end

   assign lkup.hit   = |match;
   assign lkup.full  = &valid_ff;
   assign lkup.score = hit_score;

   assign wr_sel = (|match) ? match : first_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (upd.wr_en && wr_sel[i]) begin
               valid_ff[i] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (upd.wr_en && wr_sel[i]) begin
            key_ff[i]   <= key;
            score_ff[i] <= upd.wr_score;
         end
      end
   end

`ifndef SYNTH
   a_unique_key: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("source key held by more than one entry");
   a_free_pick: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) == (first_free == '0))
      else $error("free entry pick disagrees with full flag");
   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      upd.wr_en && !(|match) && !(&valid_ff) |=>
         $countones(valid_ff) == $countones($past(valid_ff)) + 1)
      else $error("insert did not claim exactly one entry");
   a_valid_sticky: assert property (@(posedge clock) disable iff (reset)
      (valid_ff & ~$past(valid_ff)) == '0 || $past(upd.wr_en))
      else $error("valid bit set without an update");
`endif

endmodule

// ----- design/source_trust_score_table.sv -----
// ----------------------------------------------------------------------------
// source_trust_score_table: per-source trust score table
// Evaluate / penalize / authenticate operations on a fully associative table
// keyed by source address, one operation per clock.
// ----------------------------------------------------------------------------
//  channel   ports                                    handshake
//  --------  ---------------------------------------  -------------------------
//  request   start, busy, req_item                    beat when start & !busy
//  response  rsp_strobe, rsp_item                     one-cycle strobe, no stall
//  control   psel, penable, pwrite, paddr, pwdata,    APB, write on access phase
//            prdata, pready
//
//  One beat per clock; busy is never raised. A request is captured in the
//  input register, looked up and applied to the table during the next cycle,
//  and its response strobes from the result register, loaded with the table write.
//  The table update of one beat is visible to the very next beat.
//  Reset clears all valid bits at once; no sweep follows.
//  Responses cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module source_trust_score_table #(
   parameter int unsigned TABLE_ENTRIES = sts_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  sts_pkg::req_type                  req_item,
   output logic                              rsp_strobe,
   output sts_pkg::rsp_type                  rsp_item,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sts_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [sts_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [sts_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import sts_pkg::*;

   cfg_type    cfg;
   lookup_type lkup;
   update_type upd;

   logic       item_valid_ff;
   req_type    item_ff;
   logic       rsp_strobe_ff;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   op_type     op;
   logic [SCORE_W-1:0] auth_score;
   logic [SCORE_W-1:0] pen_score;

   assign busy = 1'b0;

   sts_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sts_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .key   (item_ff.src_address),
      .upd   (upd),
      .lkup  (lkup)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start & ~busy) begin
         item_ff <= req_item;
      end
   end

   assign op         = op_type'(item_ff.op);
   assign auth_score = item_ff.mfa_passed ? cfg.mfa_score : cfg.plain_score;
   // saturate at zero when the penalty reaches the score
   assign pen_score  = (item_ff.penalty_points >= {1'b0, lkup.score}) ? '0 :
                       (lkup.score - item_ff.penalty_points[SCORE_W-1:0]);

   always_comb begin
      rsp_in.allow    = 1'b0;
      rsp_in.score    = '0;
      rsp_in.status   = ST_IGNORED;
      upd.wr_en       = 1'b0;
      upd.wr_score    = '0;
      unique case (op)
         OP_EVALUATE: begin
            if (lkup.hit) begin
               rsp_in.status = ST_FOUND;
               rsp_in.score  = lkup.score;
               rsp_in.allow  = (lkup.score >= cfg.min_score);
            end else if (!lkup.full) begin
               rsp_in.status = ST_CREATED;
               rsp_in.score  = cfg.anonymous_score;
               rsp_in.allow  = (cfg.anonymous_score >= cfg.min_score);
               upd.wr_en     = 1'b1;
               upd.wr_score  = cfg.anonymous_score;
            end else begin
               // full table: fail open
               rsp_in.status = ST_FULL;
               rsp_in.allow  = 1'b1;
            end
         end
         OP_PENALIZE: begin
            if (lkup.hit) begin
               rsp_in.status = ST_FOUND;
               rsp_in.score  = pen_score;
               upd.wr_en     = 1'b1;
               upd.wr_score  = pen_score;
            end
         end
         OP_AUTHENTICATE: begin
            if (lkup.hit || !lkup.full) begin
               rsp_in.status = lkup.hit ? ST_FOUND : ST_CREATED;
               rsp_in.score  = auth_score;
               upd.wr_en     = 1'b1;
               upd.wr_score  = auth_score;
            end else begin
               rsp_in.status = ST_FULL;
            end
         end
         default: begin
            rsp_in.status = ST_IGNORED;
         end
      endcase
      upd.wr_en = upd.wr_en & item_valid_ff;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef SYNTH
   a_one_rsp_per_beat: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff |=> rsp_strobe)
      else $error("accepted beat produced no response");
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !item_valid_ff |=> !rsp_strobe)
      else $error("response without an accepted beat");
   a_full_no_score: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status == ST_FULL |-> rsp_item.score == '0)
      else $error("full-table response carries a score");
   a_allow_eval_only: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && op != OP_EVALUATE |=> !rsp_item.allow)
      else $error("allow raised on a non-evaluate beat");
   a_no_write_on_idle: assert property (@(posedge clock) disable iff (reset)
      !item_valid_ff |-> !upd.wr_en)
      else $error("table update without a beat in flight");
`endif

endmodule
